### sv/random_prim_maze_carver_defines.svh
// ----------------------------------------------------------------------------
// random_prim_maze_carver_defines
// Assertion macros for the maze carver.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PRIM_MAZE_CARVER_DEFINES_SVH
`define RANDOM_PRIM_MAZE_CARVER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RPMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### sv/rpmc_pkg.sv
// ----------------------------------------------------------------------------
// rpmc_pkg
// Types, constants and codes shared by the maze carver modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rpmc_pkg;
  localparam int unsigned MAZE_ROWS_DEF = 31;
  localparam int unsigned MAZE_COLS_DEF = 63;

  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;

  localparam logic [2:0] CELL_WALL   = 3'd0;
  localparam logic [2:0] CELL_NODE   = 3'd1;
  localparam logic [2:0] CELL_FRONT  = 3'd2;
  localparam logic [2:0] CELL_ROAD   = 3'd3;
  localparam logic [2:0] CELL_REJECT = 3'd4;

  localparam logic [2:0] ST_CARVED = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_DONE   = 3'd2;
  localparam logic [2:0] ST_INIT   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_FILL, S_START, S_MOD, S_LRD, S_LWAIT, S_NRD, S_NWAIT, S_NCHK,
    S_LASTRD, S_LASTWAIT, S_SWAP, S_MARK, S_PROBE, S_PWAIT, S_PUSH, S_RRD, S_RWAIT,
    S_OUT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;     // latch input item
    logic fill_clr;    // reset counters and fill address
    logic fill_wr;     // write one fill cell, advance
    logic start;       // mark start cell, set node address (1,1)
    logic mod_start;
    logic lst_rd_pick;
    logic lst_rd_last;
    logic lst_wr_pick;
    logic take_wall;   // latch wall position from list read
    logic nbr_rd;      // read grid at neighbor (dir)
    logic nbr_next;    // advance dir
    logic found_set;   // neighbor is node: record node
    logic mark_wall;   // write wall cell (road/reject), dec frontier
    logic mark_node;   // write node as road, dec unvisited
    logic probe_rd;    // read grid at frontier probe (dir)
    logic push;        // push probed wall
    logic read_rd;
    logic set_done;
    logic set_init;
    logic set_res;     // step result status
    logic set_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mod_done;
    logic finished;    // unvisited or frontier zero
    logic dir_ok;      // current dir in range
    logic dir_last;    // dir == 3
    logic rd_is_node;
    logic rd_is_wall;
    logic found;
    logic front_full;
    logic mark_node_pend;
  } sts_t;
endpackage
`default_nettype wire

### sv/rpmc_if.sv
// ----------------------------------------------------------------------------
// rpmc_in_if / rpmc_out_if
// Valid/ready channels for maze carver requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface rpmc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [30:0] random_value;
  logic [4:0]  read_row;
  logic [5:0]  read_col;
  modport source (output valid, action, random_value, read_row, read_col, input ready);
  modport sink (input valid, action, random_value, read_row, read_col, output ready);
endinterface

interface rpmc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] wall_row;
  logic [5:0] wall_col;
  logic [4:0] node_row;
  logic [5:0] node_col;
  logic [2:0] cell_code;
  logic [8:0] nodes_left;
  logic [10:0] frontier_left;
  modport source (output valid, status, wall_row, wall_col, node_row, node_col, cell_code,
                  nodes_left, frontier_left, input ready);
  modport sink (input valid, status, wall_row, wall_col, node_row, node_col, cell_code,
                nodes_left, frontier_left, output ready);
endinterface
`default_nettype wire

### sv/random_prim_maze_carver.sv
// ----------------------------------------------------------------------------
// random_prim_maze_carver
// Randomized Prim maze generator over a grid memory and a frontier list.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | action, random_value, read_row, read_col
// out_    | out | status, wall/node position, cell_code, nodes_left, frontier_left
//
// One request at a time. Init accepts the request, sweeps the grid one cell
// per cycle, marks the start cell, probes around it and loads the result.
// Step runs the bit-serial modulo, then control, grid and list memory
// accesses; read makes one grid access. Result waits in an output register
// while out_ready is low. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "random_prim_maze_carver_defines.svh"
module random_prim_maze_carver #(
  parameter int unsigned MAZE_ROWS = rpmc_pkg::MAZE_ROWS_DEF,
  parameter int unsigned MAZE_COLS = rpmc_pkg::MAZE_COLS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rpmc_in_if.sink    in_ch,
  rpmc_out_if.source out_ch
);
  rpmc_pkg::cmd_t cmd;
  rpmc_pkg::sts_t sts;
  logic out_valid_r, res_load;

  rpmc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_action(in_ch.action),
    .in_ready(in_ch.ready), .res_load(res_load), .res_busy(out_valid_r && !out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  rpmc_dp #(.MAZE_ROWS(MAZE_ROWS), .MAZE_COLS(MAZE_COLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_random_value(in_ch.random_value),
    .in_read_row(in_ch.read_row), .in_read_col(in_ch.read_col),
    .r_status(out_ch.status), .r_wall_row(out_ch.wall_row), .r_wall_col(out_ch.wall_col),
    .r_node_row(out_ch.node_row), .r_node_col(out_ch.node_col),
    .r_cell_code(out_ch.cell_code), .r_nodes_left(out_ch.nodes_left),
    .r_frontier_left(out_ch.frontier_left)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  assign out_ch.valid = out_valid_r;

  `RPMC_ASSERT_IMP(a_load_free, res_load, !out_valid_r || out_ch.ready, "result overwritten")
  `RPMC_ASSERT_NEXT(a_load_valid, res_load, out_valid_r, "loaded result not shown")
  `RPMC_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_ch.status), "stalled result changed")
endmodule
`default_nettype wire

### sv/rpmc_ram.sv
// ----------------------------------------------------------------------------
// rpmc_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rpmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/rpmc_ctrl.sv
// ----------------------------------------------------------------------------
// rpmc_ctrl
// Sequencer for init, step and read requests.
// ----------------------------------------------------------------------------
`default_nettype none
module rpmc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_action,
  output logic                 in_ready,
  output logic                 res_load,
  input  wire logic            res_busy,
  input  wire rpmc_pkg::sts_t  sts,
  output rpmc_pkg::cmd_t       cmd
);
  rpmc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      rpmc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == rpmc_pkg::ACT_INIT) begin
            cmd.fill_clr = 1'b1;
            state_nxt = rpmc_pkg::S_FILL;
          end else if (in_action == rpmc_pkg::ACT_STEP) begin
            state_nxt = rpmc_pkg::S_MOD;
          end else begin
            state_nxt = rpmc_pkg::S_RRD;
          end
        end
      end
      rpmc_pkg::S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_nxt = rpmc_pkg::S_START;
      end
      rpmc_pkg::S_START: begin
        cmd.start = 1'b1;
        state_nxt = rpmc_pkg::S_PROBE;
      end
      rpmc_pkg::S_MOD: begin
        if (sts.finished) begin
          cmd.set_done = 1'b1;
          state_nxt = rpmc_pkg::S_OUT;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt = rpmc_pkg::S_LRD;
        end
      end
      rpmc_pkg::S_LRD: begin
        if (sts.mod_done) begin
          cmd.lst_rd_pick = 1'b1;
          state_nxt = rpmc_pkg::S_LWAIT;
        end
      end
      rpmc_pkg::S_LWAIT: begin
        cmd.take_wall = 1'b1;
        state_nxt = rpmc_pkg::S_NRD;
      end
      rpmc_pkg::S_NRD: begin
        if (sts.dir_ok) begin
          cmd.nbr_rd = 1'b1;
          state_nxt = rpmc_pkg::S_NWAIT;
        end else if (sts.dir_last) begin
          state_nxt = rpmc_pkg::S_LASTRD;
        end else begin
          cmd.nbr_next = 1'b1;
        end
      end
      rpmc_pkg::S_NWAIT: state_nxt = rpmc_pkg::S_NCHK;
      rpmc_pkg::S_NCHK: begin
        if (sts.rd_is_node) begin
          cmd.found_set = 1'b1;
          state_nxt = rpmc_pkg::S_LASTRD;
        end else if (sts.dir_last) begin
          state_nxt = rpmc_pkg::S_LASTRD;
        end else begin
          cmd.nbr_next = 1'b1;
          state_nxt = rpmc_pkg::S_NRD;
        end
      end
      rpmc_pkg::S_LASTRD: begin
        cmd.lst_rd_last = 1'b1;
        state_nxt = rpmc_pkg::S_LASTWAIT;
      end
      rpmc_pkg::S_LASTWAIT: state_nxt = rpmc_pkg::S_SWAP;
      rpmc_pkg::S_SWAP: begin
        cmd.lst_wr_pick = 1'b1;
        state_nxt = rpmc_pkg::S_MARK;
      end
      rpmc_pkg::S_MARK: begin
        if (sts.mark_node_pend) begin
          cmd.mark_node = 1'b1;
          state_nxt = rpmc_pkg::S_PROBE;
        end else begin
          cmd.mark_wall = 1'b1;
          cmd.set_res   = 1'b1;
          if (!sts.found) state_nxt = rpmc_pkg::S_OUT;
        end
      end
      rpmc_pkg::S_PROBE: begin
        if (sts.dir_ok) begin
          cmd.probe_rd = 1'b1;
          state_nxt = rpmc_pkg::S_PWAIT;
        end else if (sts.dir_last) begin
          state_nxt = rpmc_pkg::S_OUT;
        end else begin
          cmd.nbr_next = 1'b1;
        end
      end
      rpmc_pkg::S_PWAIT: state_nxt = rpmc_pkg::S_PUSH;
      rpmc_pkg::S_PUSH: begin
        if (sts.rd_is_wall && !sts.front_full) cmd.push = 1'b1;
        if (sts.dir_last) begin
          state_nxt = rpmc_pkg::S_OUT;
        end else begin
          cmd.nbr_next = 1'b1;
          state_nxt = rpmc_pkg::S_PROBE;
        end
      end
      rpmc_pkg::S_RRD: begin
        cmd.read_rd = 1'b1;
        state_nxt = rpmc_pkg::S_RWAIT;
      end
      rpmc_pkg::S_RWAIT: begin
        cmd.set_read = 1'b1;
        state_nxt = rpmc_pkg::S_OUT;
      end
      rpmc_pkg::S_OUT: begin
        if (!res_busy) begin
          res_load = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt = rpmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = rpmc_pkg::S_IDLE;
    endcase
    // init result status
    if (state_r == rpmc_pkg::S_START) cmd.set_init = 1'b1;
  end
endmodule
`default_nettype wire

### sv/rpmc_dp.sv
// ----------------------------------------------------------------------------
// rpmc_dp
// Grid and frontier memories, counters, modulo unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rpmc_dp #(
  parameter int unsigned MAZE_ROWS = rpmc_pkg::MAZE_ROWS_DEF,
  parameter int unsigned MAZE_COLS = rpmc_pkg::MAZE_COLS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rpmc_pkg::cmd_t cmd,
  output rpmc_pkg::sts_t      sts,
  input  wire logic [30:0]    in_random_value,
  input  wire logic [4:0]     in_read_row,
  input  wire logic [5:0]     in_read_col,
  output logic [2:0]          r_status,
  output logic [4:0]          r_wall_row,
  output logic [5:0]          r_wall_col,
  output logic [4:0]          r_node_row,
  output logic [5:0]          r_node_col,
  output logic [2:0]          r_cell_code,
  output logic [8:0]          r_nodes_left,
  output logic [10:0]         r_frontier_left
);
  localparam int unsigned NCELLS = MAZE_ROWS * MAZE_COLS;
  localparam int unsigned AW = $clog2(NCELLS);
  localparam int unsigned RW = $clog2(MAZE_ROWS);
  localparam int unsigned CW = $clog2(MAZE_COLS);
  localparam int unsigned FW = $clog2(NCELLS + 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAZE_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(MAZE_COLS - 1);

  // captured request
  logic [30:0] rnd_r;
  logic [4:0]  rrow_r;
  logic [5:0]  rcol_r;
  // counters
  logic [FW-1:0] fcnt_r;
  logic [FW-1:0] ucnt_r;
  // fill sweep
  logic [RW-1:0] frow_r;
  logic [CW-1:0] fcol_r;
  logic [AW-1:0] faddr_r;
  // step position registers
  logic [RW-1:0] wr_r, nr_r;
  logic [CW-1:0] wc_r, nc_r;
  logic [1:0]    dir_r;
  logic          found_r, node_pend_r;
  logic [FW-1:0] pick_r;
  logic [2:0]    status_r;
  logic [2:0]    code_r;
  // modulo unit: restoring, one bit per cycle
  logic [30:0]   mq_r;
  logic [FW-1:0] mrem_r;
  logic [4:0]    mbit_r;
  logic          mbusy_r;
  logic [FW:0]   mtrial;

  // probe position for current dir around center
  logic [RW-1:0] crow;
  logic [CW-1:0] ccol;
  logic [RW-1:0] prow;
  logic [CW-1:0] pcol;
  logic          p_ok;

  // grid ram
  logic          g_we;
  logic [AW-1:0] g_addr;
  logic [2:0]    g_wdata, g_rdata;
  // list ram: {row,col}
  logic          l_we;
  logic [FW-1:0] l_idx;
  logic [RW+CW-1:0] l_wdata, l_rdata, last_r;

  rpmc_ram #(.WIDTH(3), .DEPTH(NCELLS)) u_grid (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata)
  );
  rpmc_ram #(.WIDTH(RW + CW), .DEPTH(NCELLS)) u_list (
    .clk(clk), .we(l_we), .addr(l_idx[AW-1:0]), .wdata(l_wdata), .rdata(l_rdata)
  );

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [AW+RW+CW:0] t;
    t = AW'(r) * (AW+RW+CW+1)'(MAZE_COLS) + (AW+RW+CW+1)'(c);
    return t[AW-1:0];
  endfunction

  // found_r selects the node as center: set when a neighbor node is found and for the start cell
  always_comb begin
    crow = found_r ? nr_r : wr_r;
    ccol = found_r ? nc_r : wc_r;
    prow = crow;
    pcol = ccol;
    p_ok = 1'b0;
    case (dir_r)
      2'd0: begin prow = crow - RW'(1); p_ok = crow > RW'(1); end
      2'd1: begin prow = crow + RW'(1); p_ok = (crow < ROW_LAST - RW'(1)); end
      2'd2: begin pcol = ccol - CW'(1); p_ok = ccol > CW'(1); end
      default: begin pcol = ccol + CW'(1); p_ok = (ccol < COL_LAST - CW'(1)); end
    endcase
  end

  assign mtrial = {mrem_r, mq_r[30]} - {1'b0, fcnt_r};

  always_comb begin
    g_we = 1'b0;
    g_addr = cell_addr(prow, pcol);
    g_wdata = rpmc_pkg::CELL_WALL;
    if (cmd.fill_wr) begin
      g_we = 1'b1;
      g_addr = faddr_r;
      g_wdata = (frow_r[0] && fcol_r[0]) ? rpmc_pkg::CELL_NODE : rpmc_pkg::CELL_WALL;
    end else if (cmd.start) begin
      g_we = 1'b1;
      g_addr = cell_addr(RW'(1), CW'(1));
      g_wdata = rpmc_pkg::CELL_ROAD;
    end else if (cmd.mark_wall) begin
      g_we = 1'b1;
      g_addr = cell_addr(wr_r, wc_r);
      g_wdata = found_r ? rpmc_pkg::CELL_ROAD : rpmc_pkg::CELL_REJECT;
    end else if (cmd.mark_node) begin
      g_we = 1'b1;
      g_addr = cell_addr(nr_r, nc_r);
      g_wdata = rpmc_pkg::CELL_ROAD;
    end else if (cmd.push) begin
      g_we = 1'b1;
      g_wdata = rpmc_pkg::CELL_FRONT;
    end else if (cmd.read_rd) begin
      g_addr = cell_addr(RW'(rrow_r), CW'(rcol_r));
    end
  end

  always_comb begin
    l_we = 1'b0;
    l_idx = pick_r;
    l_wdata = last_r;
    if (cmd.lst_rd_pick) begin
      l_idx = mrem_r;
    end else if (cmd.lst_rd_last) begin
      l_idx = fcnt_r - FW'(1);
    end else if (cmd.push) begin
      l_we = 1'b1;
      l_idx = fcnt_r;
      l_wdata = {prow, pcol};
    end else if (cmd.lst_wr_pick) begin
      l_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r  <= '0;
      ucnt_r  <= '0;
      mbusy_r <= 1'b0;
      dir_r   <= '0;
      found_r <= 1'b0;
      node_pend_r <= 1'b0;
    end else begin
      if (cmd.fill_clr) begin
        fcnt_r <= '0;
        ucnt_r <= '0;
      end
      if (cmd.fill_wr && frow_r[0] && fcol_r[0]) ucnt_r <= ucnt_r + FW'(1);
      if (cmd.start) begin
        ucnt_r  <= ucnt_r - FW'(1);
        found_r <= 1'b1;
        dir_r   <= '0;
      end
      if (cmd.mod_start) begin
        mbusy_r <= 1'b1;
        dir_r   <= '0;
        found_r <= 1'b0;
      end else if (mbusy_r) begin
        if (mbit_r == 5'd30) mbusy_r <= 1'b0;
      end
      if (cmd.nbr_next) dir_r <= dir_r + 2'd1;
      if (cmd.found_set) found_r <= 1'b1;
      // wall is marked first; the node follows in the next cycle
      if (cmd.mark_wall) begin
        fcnt_r <= fcnt_r - FW'(1);
        node_pend_r <= found_r;
      end
      if (cmd.mark_node) begin
        ucnt_r <= ucnt_r - FW'(1);
        node_pend_r <= 1'b0;
        dir_r <= '0;
      end
      if (cmd.push) fcnt_r <= fcnt_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rnd_r  <= in_random_value;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
      status_r <= rpmc_pkg::ST_DONE;
      code_r <= rpmc_pkg::CELL_WALL;
      wr_r <= '0; wc_r <= '0; nr_r <= '0; nc_r <= '0;
    end
    if (cmd.fill_clr) begin
      frow_r <= '0; fcol_r <= '0; faddr_r <= '0;
    end else if (cmd.fill_wr) begin
      faddr_r <= faddr_r + AW'(1);
      if (fcol_r == COL_LAST) begin
        fcol_r <= '0;
        frow_r <= frow_r + RW'(1);
      end else begin
        fcol_r <= fcol_r + CW'(1);
      end
    end
    if (cmd.start) begin
      nr_r <= RW'(1); nc_r <= CW'(1);
    end
    if (cmd.mod_start) begin
      mq_r <= rnd_r; mrem_r <= '0; mbit_r <= '0;
    end else if (mbusy_r) begin
      mq_r <= {mq_r[29:0], 1'b0};
      mbit_r <= mbit_r + 5'd1;
      if (!mtrial[FW]) mrem_r <= mtrial[FW-1:0];
      else mrem_r <= {mrem_r[FW-2:0], mq_r[30]};
    end
    if (cmd.lst_rd_pick) pick_r <= mrem_r;
    if (cmd.take_wall) {wr_r, wc_r} <= l_rdata;
    if (cmd.found_set) begin
      nr_r <= prow; nc_r <= pcol;
    end
    if (cmd.set_done) status_r <= rpmc_pkg::ST_DONE;
    if (cmd.set_init) status_r <= rpmc_pkg::ST_INIT;
    if (cmd.set_res)
      status_r <= found_r ? rpmc_pkg::ST_CARVED : rpmc_pkg::ST_REJECT;
    if (cmd.set_read) begin
      status_r <= rpmc_pkg::ST_READ;
      code_r <= (32'(rrow_r) < MAZE_ROWS && 32'(rcol_r) < MAZE_COLS) ? g_rdata
                : rpmc_pkg::CELL_WALL;
    end
    if (cmd.out_load) begin
      r_status <= status_r;
      r_wall_row <= 5'(wr_r); r_wall_col <= 6'(wc_r);
      r_node_row <= (status_r == rpmc_pkg::ST_CARVED) ? 5'(nr_r) : 5'd0;
      r_node_col <= (status_r == rpmc_pkg::ST_CARVED) ? 6'(nc_r) : 6'd0;
      r_cell_code <= code_r;
      r_nodes_left <= 9'(ucnt_r);
      r_frontier_left <= 11'(fcnt_r);
    end
  end

  // last entry is read in S_LASTRD and registered into last_r for the swap write in S_SWAP
  logic lastrd_d_r;
  always_ff @(posedge clk) begin
    lastrd_d_r <= cmd.lst_rd_last;
    if (lastrd_d_r) last_r <= l_rdata;
  end

  assign sts.fill_last = (faddr_r == AW'(NCELLS - 1));
  assign sts.mod_done  = !mbusy_r && !cmd.mod_start;
  assign sts.finished  = (ucnt_r == '0) || (fcnt_r == '0);
  assign sts.dir_ok    = p_ok;
  assign sts.dir_last  = (dir_r == 2'd3);
  assign sts.rd_is_node = (g_rdata == rpmc_pkg::CELL_NODE);
  assign sts.rd_is_wall = (g_rdata == rpmc_pkg::CELL_WALL);
  assign sts.found     = found_r;
  assign sts.front_full = (32'(fcnt_r) >= NCELLS);
  assign sts.mark_node_pend = node_pend_r;
endmodule
`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Maze carver testbench
// Drives init, step and read requests through the input channel, predicts
// every result with a behavioral maze model and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  localparam int ROWS = 31;
  localparam int COLS = 63;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_READ_ALT = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] rnd;
    logic [4:0]  row;
    logic [5:0]  col;
  } maze_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  wall_row;
    logic [5:0]  wall_col;
    logic [4:0]  node_row;
    logic [5:0]  node_col;
    logic [2:0]  code;
    logic [8:0]  nodes_left;
    logic [10:0] frontier_left;
  } maze_res_t;

  logic clk = 0;
  logic rst_n = 0;

  rpmc_in_if  in_ch();
  rpmc_out_if out_ch();

  random_prim_maze_carver dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // ---- maze model state ----
  logic [2:0] grid [ROWS][COLS];
  int         fr_row [ROWS*COLS];
  int         fr_col [ROWS*COLS];
  int         fr_cnt = 0;
  int         unvisited = 0;

  maze_req_t pending_reqs[$];
  maze_res_t expected_res[$];
  int        errors = 0;
  int        results_seen = 0;
  int        carved_cnt = 0, rejected_cnt = 0, done_cnt = 0;
  int        send_idle_pct = 0, recv_stall_pct = 0;
  bit        hold_recv = 0;

  task automatic push_wall(int r, int c);
    if (grid[r][c] == rpmc_pkg::CELL_WALL && fr_cnt < ROWS*COLS) begin
      grid[r][c] = rpmc_pkg::CELL_FRONT;
      fr_row[fr_cnt] = r;
      fr_col[fr_cnt] = c;
      fr_cnt++;
    end
  endtask

  task automatic add_frontier(int r, int c);
    if (r > 1) push_wall(r - 1, c);
    if (r + 2 < ROWS) push_wall(r + 1, c);
    if (c > 1) push_wall(r, c - 1);
    if (c + 2 < COLS) push_wall(r, c + 1);
  endtask

  function automatic bit is_node(int r, int c);
    return grid[r][c] == rpmc_pkg::CELL_NODE;
  endfunction

  task automatic predict_maze(input maze_req_t q, output maze_res_t res);
    int pick, wr, wc, nr, nc;
    bit found;
    res = '0;
    if (q.action == rpmc_pkg::ACT_INIT) begin
      unvisited = 0;
      fr_cnt = 0;
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < COLS; c++)
          if (r[0] && c[0]) begin
            grid[r][c] = rpmc_pkg::CELL_NODE;
            unvisited++;
          end else begin
            grid[r][c] = rpmc_pkg::CELL_WALL;
          end
      grid[1][1] = rpmc_pkg::CELL_ROAD;
      unvisited--;
      add_frontier(1, 1);
      res.status = rpmc_pkg::ST_INIT;
    end else if (q.action == rpmc_pkg::ACT_STEP) begin
      if (unvisited == 0 || fr_cnt == 0) begin
        res.status = rpmc_pkg::ST_DONE;
      end else begin
        pick = int'(q.rnd) % fr_cnt;
        wr = fr_row[pick];
        wc = fr_col[pick];
        found = 1;
        nr = 0;
        nc = 0;
        if (wr > 1 && is_node(wr - 1, wc)) begin
          nr = wr - 1; nc = wc;
        end else if (wr + 2 < ROWS && is_node(wr + 1, wc)) begin
          nr = wr + 1; nc = wc;
        end else if (wc > 1 && is_node(wr, wc - 1)) begin
          nr = wr; nc = wc - 1;
        end else if (wc + 2 < COLS && is_node(wr, wc + 1)) begin
          nr = wr; nc = wc + 1;
        end else begin
          found = 0;
        end
        fr_row[pick] = fr_row[fr_cnt - 1];
        fr_col[pick] = fr_col[fr_cnt - 1];
        fr_cnt--;
        res.wall_row = 5'(wr);
        res.wall_col = 6'(wc);
        if (found) begin
          grid[wr][wc] = rpmc_pkg::CELL_ROAD;
          grid[nr][nc] = rpmc_pkg::CELL_ROAD;
          unvisited--;
          add_frontier(nr, nc);
          res.node_row = 5'(nr);
          res.node_col = 6'(nc);
          res.status = rpmc_pkg::ST_CARVED;
        end else begin
          grid[wr][wc] = rpmc_pkg::CELL_REJECT;
          res.status = rpmc_pkg::ST_REJECT;
        end
      end
    end else begin
      if (q.row < ROWS && q.col < COLS) res.code = grid[q.row][q.col];
      res.status = rpmc_pkg::ST_READ;
    end
    res.nodes_left = unvisited[8:0];
    res.frontier_left = fr_cnt[10:0];
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // ---- driver ----
  initial begin
    in_ch.valid = 0;
    in_ch.action = '0;
    in_ch.random_value = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    maze_res_t res;
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_maze({in_ch.action, in_ch.random_value, in_ch.read_row, in_ch.read_col}, res);
        expected_res.push_back(res);
      end
      if ((!in_ch.valid || in_ch.ready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          maze_req_t q;
          q = pending_reqs.pop_front();
          in_ch.valid <= 1;
          in_ch.action <= q.action;
          in_ch.random_value <= q.rnd;
          in_ch.read_row <= q.row;
          in_ch.read_col <= q.col;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    maze_res_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $display("result %0d arrived with nothing expected", results_seen);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
          if (out_ch.wall_row !== e.wall_row)
            report_mismatch("wall_row", out_ch.wall_row, e.wall_row);
          if (out_ch.wall_col !== e.wall_col)
            report_mismatch("wall_col", out_ch.wall_col, e.wall_col);
          if (out_ch.node_row !== e.node_row)
            report_mismatch("node_row", out_ch.node_row, e.node_row);
          if (out_ch.node_col !== e.node_col)
            report_mismatch("node_col", out_ch.node_col, e.node_col);
          if (out_ch.cell_code !== e.code) report_mismatch("cell_code", out_ch.cell_code, e.code);
          if (out_ch.nodes_left !== e.nodes_left)
            report_mismatch("nodes_left", out_ch.nodes_left, e.nodes_left);
          if (out_ch.frontier_left !== e.frontier_left)
            report_mismatch("frontier_left", out_ch.frontier_left, e.frontier_left);
          case (e.status)
            rpmc_pkg::ST_CARVED: carved_cnt++;
            rpmc_pkg::ST_REJECT: rejected_cnt++;
            rpmc_pkg::ST_DONE:   done_cnt++;
            default: ;
          endcase
        end
      end
      out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- stimulus ----
  function automatic maze_req_t make_req(logic [1:0] a, logic [30:0] r, logic [4:0] row,
                                         logic [5:0] col);
    maze_req_t q;
    q.action = a; q.rnd = r; q.row = row; q.col = col;
    return q;
  endfunction

  // used only after the first init, so every read sees a written grid
  function automatic maze_req_t rand_req();
    int k;
    k = $urandom_range(99);
    if (k < 2) return make_req(rpmc_pkg::ACT_INIT, 31'($urandom), 5'($urandom), 6'($urandom));
    if (k < 70) return make_req(rpmc_pkg::ACT_STEP, 31'($urandom), 5'($urandom), 6'($urandom));
    if (k < 85) return make_req(ACT_READ, 31'($urandom), 5'($urandom_range(ROWS - 1)),
                                6'($urandom_range(COLS - 1)));
    return make_req(ACT_READ_ALT, 31'($urandom), 5'($urandom), 6'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_res.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // directed: finished step before init, init, field extremes, outside reads
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_STEP, 31'h7fffffff, 5'd31, 6'd63));
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_INIT, '0, '0, '0));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd1, 6'd1));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd1, 6'd2));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd0, 6'd0));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd30, 6'd62));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd31, 6'd5));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd3, 6'd63));
    pending_reqs.push_back(make_req(ACT_READ_ALT, 31'h7fffffff, 5'd3, 6'd3));
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_STEP, '0, '0, '0));
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_STEP, 31'h7fffffff, '0, '0));
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_STEP, 31'h2aaaaaaa, 5'h15, 6'h2a));
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_STEP, 31'h55555555, 5'h0a, 6'h15));
    pending_reqs.push_back(make_req(ACT_READ, '0, 5'd1, 6'd2));
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_INIT, 31'h7fffffff, 5'd31, 6'd63));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 51 : 16) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 51 : 16) : 0;
      for (int i = 0; i < 250; i++) pending_reqs.push_back(rand_req());
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      wait_drained();
    end
    // run one maze to completion so stepping past the end is reached
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pending_reqs.push_back(make_req(rpmc_pkg::ACT_INIT, '0, '0, '0));
    for (int i = 0; i < 900; i++)
      pending_reqs.push_back(make_req(rpmc_pkg::ACT_STEP, 31'($urandom), '0, '0));
    for (int i = 0; i < 20; i++)
      pending_reqs.push_back(make_req(ACT_READ, '0, 5'($urandom_range(ROWS - 1)),
                                      6'($urandom_range(COLS - 1))));
    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d results: %0d carves, %0d rejects, %0d finished steps",
             results_seen, carved_cnt, rejected_cnt, done_cnt);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end
endmodule

### random_prim_maze_carver.f
+incdir+sv
sv/rpmc_pkg.sv
sv/rpmc_if.sv
sv/rpmc_ram.sv
sv/rpmc_ctrl.sv
sv/rpmc_dp.sv
sv/random_prim_maze_carver.sv
verif/tb_top.sv
